// File: rtl/core/gst_pkg.sv
`default_nettype none
package gst_pkg;

  localparam int unsigned MAX_TOK = 3;

  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    TOK_LIT   = 3'd0,
    TOK_ANYC  = 3'd1,
    TOK_ANYS  = 3'd2,
    TOK_OPENW = 3'd3,
    TOK_OPENX = 3'd4,
    TOK_RANGE = 3'd5,
    TOK_CLOSE = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_OPENED  = 3'd2,
    MODE_NEGATED = 3'd3,
    MODE_BODY    = 3'd4,
    MODE_HELD    = 3'd5,
    MODE_DASH    = 3'd6
  } mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] lo;
    logic [7:0] hi;
  } token_t;

  typedef struct packed {
    token_t [MAX_TOK-1:0] tok;
    logic   [1:0]         cnt;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic bundle_t bundle_push(bundle_t b, kind_t k, logic [7:0] lo,
                                          logic [7:0] hi);
    bundle_t r;
    token_t  t;
    r      = b;
    t.kind = k;
    t.lo   = lo;
    t.hi   = hi;
    case (b.cnt)
      2'd0: begin
        r.tok[0] = t;
      end
      2'd1: begin
        r.tok[1] = t;
      end
      default: begin
        r.tok[2] = t;
      end
    endcase
    r.cnt = b.cnt + 2'd1;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/glob_segment_tokenizer.sv
// Glob segment tokenizer.
// Input stream s_*: one pattern byte per word in s_tdata[7:0], s_tlast high on
// the final byte of a segment. Output stream m_*: one token per word, kind in
// m_tuser[2:0], range low in m_tdata[7:0], range high in m_tdata[15:8], and
// m_tlast high on the last token caused by an input byte. Bytes that cause no
// token produce no output word.
// A front stage decodes each byte into a group of zero to three tokens and
// writes the group into a two-entry queue; a back stage sends the group one
// token per cycle while m_tready is high.
// The first token of a byte is registered in the queue before it appears on
// m_*. Throughput: one byte per cycle while m_tready stays high and each byte
// yields at most one token; a multi-token byte holds the output until all are sent.
// When the receiver stalls, the queue fills and s_tready drops after two
// pending groups; nothing is dropped. Reset empties the queue and returns the
// parser to normal mode outside any class.
`default_nettype none
module glob_segment_tokenizer
  import gst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] pattern_byte
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] range_low, [15:8] range_high
  output logic [2:0]       m_tuser,   // [2:0] token_kind
  output logic             m_tlast
);

  qstat_t  qstat;
  logic    push;
  bundle_t push_data;
  logic    pop;
  bundle_t head;

  gst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  gst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  gst_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no output pending");

  a_group_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> head.cnt != 2'd0)
    else $error("empty token group in queue");

  a_literal_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == TOK_LIT |-> m_tdata[7:0] == m_tdata[15:8])
    else $error("literal token with differing bounds");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |-> m_tlast && m_tready && m_tvalid)
    else $error("group released before its last token");
`endif

endmodule
`default_nettype wire

// File: rtl/core/gst_front.sv
`default_nettype none
module gst_front
  import gst_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] pattern_byte
  input  wire logic       s_tlast,
  input  wire qstat_t     qstat,
  output logic            push,
  output bundle_t         push_data
);

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic       accept;
  logic       first;
  logic       body;
  logic [7:0] b;
  bundle_t    bnd;

  assign s_tready = !qstat.full;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;

  always_comb begin
    bnd       = '0;
    mode_next = mode;
    held_next = held;
    first     = 1'b0;
    body      = 1'b0;

    case (mode)
      MODE_ESC: begin
        bnd       = bundle_push(bnd, TOK_LIT, b, b);
        mode_next = MODE_NORMAL;
      end
      MODE_OPENED: begin
        if (b == CH_BANG || b == CH_CARET) begin
          bnd       = bundle_push(bnd, TOK_OPENX, 8'h00, 8'h00);
          mode_next = MODE_NEGATED;
        end else begin
          bnd   = bundle_push(bnd, TOK_OPENW, 8'h00, 8'h00);
          first = 1'b1;
        end
      end
      MODE_NEGATED: begin
        first = 1'b1;
      end
      MODE_BODY: begin
        body = 1'b1;
      end
      MODE_HELD: begin
        if (b == CH_DASH) begin
          mode_next = MODE_DASH;
        end else begin
          bnd  = bundle_push(bnd, TOK_RANGE, held, held);
          body = 1'b1;
        end
      end
      MODE_DASH: begin
        if (b == CH_RBRACK) begin
          bnd       = bundle_push(bnd, TOK_RANGE, held, held);
          bnd       = bundle_push(bnd, TOK_RANGE, CH_DASH, CH_DASH);
          bnd       = bundle_push(bnd, TOK_CLOSE, 8'h00, 8'h00);
          mode_next = MODE_NORMAL;
        end else begin
          bnd       = bundle_push(bnd, TOK_RANGE, held, b);
          mode_next = MODE_BODY;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        if (b == CH_QMARK) begin
          bnd = bundle_push(bnd, TOK_ANYC, 8'h00, 8'h00);
        end else if (b == CH_STAR) begin
          bnd = bundle_push(bnd, TOK_ANYS, 8'h00, 8'h00);
        end else if (b == CH_LBRACK) begin
          mode_next = MODE_OPENED;
        end else if (b == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          bnd = bundle_push(bnd, TOK_LIT, b, b);
        end
      end
    endcase

    if (first && b == CH_RBRACK) begin
      bnd       = bundle_push(bnd, TOK_RANGE, CH_RBRACK, CH_RBRACK);
      mode_next = MODE_BODY;
    end else if (first || body) begin
      if (b == CH_RBRACK) begin
        bnd       = bundle_push(bnd, TOK_CLOSE, 8'h00, 8'h00);
        mode_next = MODE_NORMAL;
      end else begin
        held_next = b;
        mode_next = MODE_HELD;
      end
    end

    if (s_tlast) begin
      case (mode_next)
        MODE_ESC: begin
          bnd = bundle_push(bnd, TOK_LIT, CH_BSLASH, CH_BSLASH);
        end
        MODE_OPENED: begin
          bnd = bundle_push(bnd, TOK_OPENW, 8'h00, 8'h00);
          bnd = bundle_push(bnd, TOK_CLOSE, 8'h00, 8'h00);
        end
        MODE_NEGATED, MODE_BODY: begin
          bnd = bundle_push(bnd, TOK_CLOSE, 8'h00, 8'h00);
        end
        MODE_HELD: begin
          bnd = bundle_push(bnd, TOK_RANGE, held_next, held_next);
          bnd = bundle_push(bnd, TOK_CLOSE, 8'h00, 8'h00);
        end
        MODE_DASH: begin
          bnd = bundle_push(bnd, TOK_RANGE, held_next, held_next);
          bnd = bundle_push(bnd, TOK_RANGE, CH_DASH, CH_DASH);
          bnd = bundle_push(bnd, TOK_CLOSE, 8'h00, 8'h00);
        end
        default: begin
        end
      endcase
      mode_next = MODE_NORMAL;
    end
  end

  assign push      = accept && (bnd.cnt != 2'd0);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      held <= 8'h00;
    end else if (accept) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/gst_queue.sv
`default_nettype none
module gst_queue
  import gst_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  input  wire logic    pop,
  output bundle_t      head,
  output qstat_t       qstat
);

  bundle_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10: begin
          count <= count + 2'd1;
        end
        2'b01: begin
          count <= count - 2'd1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/gst_back.sv
`default_nettype none
module gst_back
  import gst_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t head,
  input  wire qstat_t  qstat,
  output logic         pop,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output logic [15:0]  m_tdata,   // [7:0] range_low, [15:8] range_high
  output logic [2:0]   m_tuser,   // [2:0] token_kind
  output logic         m_tlast
);

  logic [1:0] idx;
  token_t     tok;
  logic       fire;

  always_comb begin
    case (idx)
      2'd0: begin
        tok = head.tok[0];
      end
      2'd1: begin
        tok = head.tok[1];
      end
      default: begin
        tok = head.tok[2];
      end
    endcase
  end

  assign m_tvalid = !qstat.empty;
  assign m_tdata  = {tok.hi, tok.lo};
  assign m_tuser  = tok.kind;
  assign m_tlast  = (idx == head.cnt - 2'd1);
  assign fire     = m_tvalid && m_tready;
  assign pop      = fire && m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= m_tlast ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import gst_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_WORDS = 32;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       eos;
  } pattern_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       last;
  } token_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  pattern_word_t pattern_q[$];
  token_exp_t    token_q[$];
  mode_t         tok_mode = MODE_NORMAL;
  logic [7:0]    tok_held = 8'h00;
  int            tx_idle_pct = 31;
  int            rx_idle_pct = 64;
  int            words_added = 0;
  int            fails = 0;
  int            cycles = 0;

  glob_segment_tokenizer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void emit(kind_t k, logic [7:0] lo, logic [7:0] hi);
    token_exp_t t;
    t.kind = k;
    t.lo   = lo;
    t.hi   = hi;
    t.last = 1'b0;
    token_q.push_back(t);
  endfunction

  function automatic void class_byte(logic [7:0] b);
    if (b == CH_RBRACK) begin
      emit(TOK_CLOSE, 8'h00, 8'h00);
      tok_mode = MODE_NORMAL;
    end else begin
      tok_held = b;
      tok_mode = MODE_HELD;
    end
  endfunction

  function automatic void class_first(logic [7:0] b);
    if (b == CH_RBRACK) begin
      emit(TOK_RANGE, CH_RBRACK, CH_RBRACK);
      tok_mode = MODE_BODY;
    end else begin
      class_byte(b);
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic eos);
    logic [7:0] h;
    int         n0;
    token_exp_t t;
    h  = tok_held;
    n0 = token_q.size();
    case (tok_mode)
      MODE_ESC: begin
        emit(TOK_LIT, b, b);
        tok_mode = MODE_NORMAL;
      end
      MODE_OPENED: begin
        if (b == CH_BANG || b == CH_CARET) begin
          emit(TOK_OPENX, 8'h00, 8'h00);
          tok_mode = MODE_NEGATED;
        end else begin
          emit(TOK_OPENW, 8'h00, 8'h00);
          class_first(b);
        end
      end
      MODE_NEGATED: class_first(b);
      MODE_BODY: class_byte(b);
      MODE_HELD: begin
        if (b == CH_DASH) begin
          tok_mode = MODE_DASH;
        end else begin
          emit(TOK_RANGE, h, h);
          class_byte(b);
        end
      end
      MODE_DASH: begin
        if (b == CH_RBRACK) begin
          emit(TOK_RANGE, h, h);
          emit(TOK_RANGE, CH_DASH, CH_DASH);
          emit(TOK_CLOSE, 8'h00, 8'h00);
          tok_mode = MODE_NORMAL;
        end else begin
          emit(TOK_RANGE, h, b);
          tok_mode = MODE_BODY;
        end
      end
      default: begin
        tok_mode = MODE_NORMAL;
        if (b == CH_QMARK) emit(TOK_ANYC, 8'h00, 8'h00);
        else if (b == CH_STAR) emit(TOK_ANYS, 8'h00, 8'h00);
        else if (b == CH_LBRACK) tok_mode = MODE_OPENED;
        else if (b == CH_BSLASH) tok_mode = MODE_ESC;
        else emit(TOK_LIT, b, b);
      end
    endcase
    if (eos) begin
      h = tok_held;
      case (tok_mode)
        MODE_ESC: emit(TOK_LIT, CH_BSLASH, CH_BSLASH);
        MODE_OPENED: begin
          emit(TOK_OPENW, 8'h00, 8'h00);
          emit(TOK_CLOSE, 8'h00, 8'h00);
        end
        MODE_NEGATED, MODE_BODY: emit(TOK_CLOSE, 8'h00, 8'h00);
        MODE_HELD: begin
          emit(TOK_RANGE, h, h);
          emit(TOK_CLOSE, 8'h00, 8'h00);
        end
        MODE_DASH: begin
          emit(TOK_RANGE, h, h);
          emit(TOK_RANGE, CH_DASH, CH_DASH);
          emit(TOK_CLOSE, 8'h00, 8'h00);
        end
        default: ;
      endcase
      tok_mode = MODE_NORMAL;
    end
    if (token_q.size() > n0) begin
      t = token_q.pop_back();
      t.last = 1'b1;
      token_q.push_back(t);
    end
  endfunction

  always @(posedge clk) begin : driver
    pattern_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) tokenize_byte(s_tdata, s_tlast);
      if (!(s_tvalid && !s_tready)) begin
        if (pattern_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          w = pattern_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= w.pbyte;
          s_tlast  <= w.eos;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    token_exp_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      if (m_tvalid && m_tready) begin
        if (token_q.size() == 0) begin
          $error("unexpected token: kind %0d low %0h high %0h", m_tuser, m_tdata[7:0],
                 m_tdata[15:8]);
          fails++;
        end else begin
          want = token_q.pop_front();
          if (m_tuser != want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, m_tuser);
            fails++;
          end
          if (m_tdata[7:0] != want.lo) begin
            $error("range_low: expected %0h, got %0h", want.lo, m_tdata[7:0]);
            fails++;
          end
          if (m_tdata[15:8] != want.hi) begin
            $error("range_high: expected %0h, got %0h", want.hi, m_tdata[15:8]);
            fails++;
          end
          if (m_tlast != want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_word(logic [7:0] b, logic eos);
    pattern_word_t w;
    w.pbyte = b;
    w.eos   = eos;
    pattern_q.push_back(w);
    words_added++;
  endtask

  task automatic push_segment(logic [7:0] seg[$]);
    foreach (seg[i]) push_word(seg[i], i == seg.size() - 1);
  endtask

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    return b;
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 7))
      0: return CH_QMARK;
      1: return CH_STAR;
      2: return CH_LBRACK;
      3: return CH_BANG;
      4: return CH_CARET;
      5: return CH_RBRACK;
      6: return CH_DASH;
      default: return CH_BSLASH;
    endcase
  endfunction

  task automatic add_segment();
    logic [7:0] seg[$];
    int         units;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) seg.push_back($urandom_range(0, 1) ? pick_special()
                                                                      : rand_byte());
    end else begin
      units = $urandom_range(1, 3);
      repeat (units) begin
        case ($urandom_range(0, 5))
          0: seg.push_back(rand_byte());
          1: seg.push_back(CH_QMARK);
          2: seg.push_back(CH_STAR);
          3: begin
            seg.push_back(CH_BSLASH);
            if ($urandom_range(0, 5) != 0) seg.push_back(rand_byte());
          end
          default: begin
            seg.push_back(CH_LBRACK);
            case ($urandom_range(0, 3))
              0: seg.push_back(CH_BANG);
              1: seg.push_back(CH_CARET);
              default: ;
            endcase
            if ($urandom_range(0, 3) == 0) seg.push_back(CH_RBRACK);
            repeat ($urandom_range(0, 3)) begin
              seg.push_back($urandom_range(0, 5) == 0 ? pick_special() : rand_byte());
              if ($urandom_range(0, 1)) begin
                seg.push_back(CH_DASH);
                if ($urandom_range(0, 3) != 0) seg.push_back(rand_byte());
              end
            end
            if ($urandom_range(0, 4) != 0) seg.push_back(CH_RBRACK);
          end
        endcase
      end
    end
    push_segment(seg);
  endtask

  task automatic add_random(int count);
    int target;
    target = words_added + count;
    while (words_added < target) add_segment();
  endtask

  task automatic wait_idle();
    while (pattern_q.size() != 0 || s_tvalid || token_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    push_segment('{8'h01, CH_QMARK, CH_STAR, 8'hFF});
    push_segment('{CH_BSLASH, CH_STAR, CH_BSLASH});
    push_segment('{CH_LBRACK, CH_CARET, CH_RBRACK, 8'h62, CH_DASH, CH_RBRACK});
    push_segment('{CH_LBRACK, 8'h78});
    push_segment('{CH_LBRACK});
    push_segment('{CH_LBRACK, 8'h61, CH_DASH});
    push_segment('{CH_LBRACK, CH_BANG});
    push_segment('{CH_LBRACK, 8'h61, 8'h80, CH_RBRACK});
    wait_idle();

    add_random(PHASE_WORDS);
    wait_idle();

    tx_idle_pct = 64;
    rx_idle_pct = 31;
    add_random(PHASE_WORDS);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    add_random(PHASE_WORDS);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (token_q.size() != 0) begin
      $error("%0d tokens never arrived", token_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
